[hdl/sdht_pkg.sv]
// ----------------------------------------------------------------------------
// sdht_pkg
// shared types, codes and helpers for the sd host command tracker
// ----------------------------------------------------------------------------
package sdht_pkg;

  // response kinds of an issue item
  localparam logic [2:0] RESP_NONE = 3'd0;
  localparam logic [2:0] RESP_R1   = 3'd1;
  localparam logic [2:0] RESP_R1B  = 3'd2;
  localparam logic [2:0] RESP_R2   = 3'd3;
  localparam logic [2:0] RESP_R3   = 3'd4;
  localparam logic [2:0] RESP_R6   = 3'd5;
  localparam logic [2:0] RESP_R7   = 3'd6;

  // item kinds
  localparam logic ITEM_ISSUE  = 1'b0;
  localparam logic ITEM_STATUS = 1'b1;

  // data size limits
  localparam int unsigned BLOCK_BYTES    = 512;
  localparam int unsigned MAX_BLOCKS     = 16'hFFFF;
  localparam logic [25:0] MAX_DATA_BYTES = 26'(MAX_BLOCKS * BLOCK_BYTES);
  localparam logic [25:0] SHORT_BYTES    = 26'd8;
  localparam logic [25:0] ONE_BLOCK      = 26'(BLOCK_BYTES);

  typedef enum logic [2:0] {
    OUT_OK          = 3'd0,
    OUT_CMD_TIMEOUT = 3'd1,
    OUT_CMD_ERROR   = 3'd2,
    OUT_DATA_ERROR  = 3'd3,
    OUT_DATA_TIMEOUT = 3'd4,
    OUT_NO_CARD     = 3'd5,
    OUT_WRONG_INT   = 3'd6,
    OUT_NOT_SUPP    = 3'd7
  } outcome_e;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [2:0]  response_kind;
    logic        has_data;
    logic        read_dir;
    logic [25:0] transfer_bytes;
    logic [15:0] normal_status;
    logic [15:0] error_status;
    logic [15:0] acmd_err_status;
  } in_item_t;

  typedef struct packed {
    logic        done_res;
    logic [2:0]  outcome;
    logic [15:0] command_word;
    logic [15:0] transfer_mode_word;
    logic [15:0] block_count;
    logic [31:0] argument_out;
    logic [15:0] ack_normal;
    logic [15:0] ack_error;
  } res_item_t;

  // words built for an issue item
  typedef struct packed {
    logic        bad_size;
    logic [15:0] command_word;
    logic [15:0] transfer_mode_word;
    logic [15:0] block_count;
  } issue_t;

  // tracking state of the command in flight
  typedef struct packed {
    logic waiting;
    logic busy_response;
    logic cmd_done_seen;
    logic xfer_done_seen;
  } track_t;

  // error word classification by priority
  function automatic outcome_e classify_error(logic [15:0] err, logic [15:0] acmd);
    outcome_e res;
    if (err[8]) begin
      res = acmd[1] ? OUT_CMD_TIMEOUT : OUT_CMD_ERROR;
    end else if (err[6:5] != 2'b00) begin
      res = OUT_DATA_ERROR;
    end else if (err[4]) begin
      res = OUT_DATA_TIMEOUT;
    end else if (err[3:1] != 3'b000) begin
      res = OUT_CMD_ERROR;
    end else if (err[0]) begin
      res = OUT_CMD_TIMEOUT;
    end else begin
      res = OUT_CMD_ERROR;
    end
    return res;
  endfunction

endpackage

[hdl/sdht_issue.sv]
// ----------------------------------------------------------------------------
// sdht_issue
// builds command, transfer mode and block count words and checks data size
// ----------------------------------------------------------------------------
module sdht_issue import sdht_pkg::*; (
  input  in_item_t item_i,
  output issue_t   issue_o
);

  logic [1:0] resp_type;
  logic       idx_chk;
  logic       crc_chk;
  logic       is_short;
  logic       multi;

  always_comb begin
    case (item_i.response_kind)
      RESP_R1, RESP_R3, RESP_R6, RESP_R7: resp_type = 2'd2;
      RESP_R1B:                           resp_type = 2'd3;
      RESP_R2:                            resp_type = 2'd1;
      default:                            resp_type = 2'd0;
    endcase
  end

  assign idx_chk  = !(item_i.response_kind inside {RESP_R2, RESP_R3});
  assign crc_chk  = (item_i.response_kind != RESP_R3);
  assign is_short = (item_i.transfer_bytes == SHORT_BYTES);
  assign multi    = (item_i.transfer_bytes > ONE_BLOCK);

  always_comb begin
    issue_o = '0;
    issue_o.bad_size = ((item_i.transfer_bytes[8:0] != 9'd0) && !is_short) ||
                       (item_i.transfer_bytes > MAX_DATA_BYTES);
    issue_o.command_word = {2'b00, item_i.cmd_index, 2'b00, item_i.has_data, idx_chk,
                            crc_chk, 1'b0, resp_type};
    // multiblock: block count enable and multi-block select
    if (multi) begin
      issue_o.transfer_mode_word[5] = 1'b1;
      issue_o.transfer_mode_word[1] = 1'b1;
      issue_o.block_count = item_i.transfer_bytes[24:9];
    end
    issue_o.transfer_mode_word[4] = item_i.read_dir;
    // auto cmd12 unless short transfer
    issue_o.transfer_mode_word[2] = !is_short;
  end

endmodule

[hdl/sdht_tracker.sv]
// ----------------------------------------------------------------------------
// sdht_tracker
// command-in-flight state and the result of one item
// ----------------------------------------------------------------------------
module sdht_tracker import sdht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  issue_t    issue_i,
  output res_item_t res_o,
  output track_t    state_o
);

  track_t state_q, state_d;
  logic   done;

  always_comb begin
    res_o   = '0;
    state_d = state_q;
    done    = 1'b0;
    if (item_i.cmd == ITEM_ISSUE) begin
      state_d = '0;
      if (!item_i.has_data) begin
        res_o.command_word    = issue_i.command_word;
        res_o.argument_out    = item_i.argument;
        state_d.waiting       = 1'b1;
        state_d.busy_response = (item_i.response_kind == RESP_R1B);
      end else if (issue_i.bad_size) begin
        done          = 1'b1;
        res_o.outcome = OUT_NOT_SUPP;
      end else begin
        done                     = 1'b1;
        res_o.command_word       = issue_i.command_word;
        res_o.transfer_mode_word = issue_i.transfer_mode_word;
        res_o.block_count        = issue_i.block_count;
        res_o.argument_out       = item_i.argument;
      end
    end else if (state_q.waiting && (item_i.normal_status != 16'd0)) begin
      res_o.ack_normal = item_i.normal_status;
      if (item_i.normal_status[15]) begin
        res_o.ack_error = item_i.error_status;
        res_o.outcome   = classify_error(item_i.error_status, item_i.acmd_err_status);
        done            = 1'b1;
      end else if (item_i.normal_status[7]) begin
        res_o.outcome = OUT_NO_CARD;
        done          = 1'b1;
      end else if (!state_q.busy_response) begin
        res_o.outcome = item_i.normal_status[0] ? OUT_OK : OUT_WRONG_INT;
        done          = 1'b1;
      end else begin
        // r1b needs both completions, possibly over several items
        if (item_i.normal_status[0]) state_d.cmd_done_seen = 1'b1;
        if (item_i.normal_status[1]) state_d.xfer_done_seen = 1'b1;
        done = state_d.cmd_done_seen && state_d.xfer_done_seen;
      end
      if (done) state_d = '0;
    end
    res_o.done_res = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

[hdl/sd_host_command_tracker.sv]
// ----------------------------------------------------------------------------
// sd_host_command_tracker
// builds sd host controller command words and tracks their completion
// ----------------------------------------------------------------------------
// Each input item yields exactly one result item. An item is registered on
// acceptance, worked out in shallow combinational logic against the
// tracking state and lands in the output register; a new item is taken in
// every cycle while the output side keeps up, and the only limit on rate is
// the single input register and the output register, which stalls the input
// only when a result is still waiting to be taken.
// Issue items return the command, transfer mode, block count and argument
// words; status items return the bits to acknowledge and, once the command
// has finished, its outcome.
module sd_host_command_tracker import sdht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output res_item_t out_item_o
);

  // input register
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  // result register
  logic      s2_valid_q;
  res_item_t s2_item_q;

  logic      advance;
  logic      in_fire;
  issue_t    issue;
  res_item_t res;
  track_t    state;

  // the registered item moves on when the result register is free or drains
  assign advance    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_item_q <= in_item_i;
  end

  // word building for issue items
  sdht_issue u_issue (
    .item_i  (s1_item_q),
    .issue_o (issue)
  );

  // state of the command in flight, updated once per item
  sdht_tracker u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (s1_item_q),
    .issue_i (issue),
    .res_o   (res),
    .state_o (state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) s2_item_q <= res;
  end

  assign out_valid_o = s2_valid_q;
  assign out_item_o  = s2_item_q;

  // outcome only carries meaning on a finished command
  a_outcome_needs_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.done_res) |-> (out_item_o.outcome == OUT_OK))
    else $error("outcome set without done");

  // a rejected transfer writes no words
  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.outcome == OUT_NOT_SUPP) |->
      (out_item_o.command_word == 16'd0 && out_item_o.argument_out == 32'd0))
    else $error("rejected issue carries words");

  // r1b tracking only exists for a command in flight
  a_busy_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.busy_response |-> state.waiting)
    else $error("busy response without command in flight");

  a_seen_needs_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state.cmd_done_seen || state.xfer_done_seen) |-> state.busy_response)
    else $error("completion flags without r1b command");

  // the input side only stalls behind a held item
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && out_stall_i))
    else $error("input stalled without a held result");

endmodule

[tb/sd_host_command_tracker_checker.sv]
// ----------------------------------------------------------------------------
// sd_host_command_tracker_checker
// watches both channels of the command tracker, predicts every result and
// compares it field by field against what the block returns
// ----------------------------------------------------------------------------
module sd_host_command_tracker_checker import sdht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  res_item_t out_item_i,
  output int        mismatches_o,
  output int        pending_o
);

  // normal status bits
  localparam int NS_CMD_DONE  = 0;
  localparam int NS_XFER_DONE = 1;
  localparam int NS_REMOVAL   = 7;
  localparam int NS_ERROR     = 15;

  // command word bits
  localparam int CW_DATA      = 5;
  localparam int CW_INDEX_CHK = 4;
  localparam int CW_CRC_CHK   = 3;

  // transfer mode bits
  localparam int TM_MULTI     = 5;
  localparam int TM_READ      = 4;
  localparam int TM_ACMD12    = 2;
  localparam int TM_BCNT_EN   = 1;

  track_t    cmd_track;
  res_item_t expected_results[$];
  int        mismatch_count;

  initial begin
    cmd_track      = '0;
    mismatch_count = 0;
  end

  function automatic logic [15:0] command_word_for(logic [5:0] idx, logic [2:0] kind,
                                                   logic data);
    logic [15:0] w;
    w        = '0;
    w[15:8]  = {2'b00, idx};
    w[CW_DATA]      = data;
    w[CW_INDEX_CHK] = !(kind == RESP_R2 || kind == RESP_R3);
    w[CW_CRC_CHK]   = (kind != RESP_R3);
    case (kind)
      RESP_R1, RESP_R3, RESP_R6, RESP_R7: w[1:0] = 2'd2;
      RESP_R1B:                           w[1:0] = 2'd3;
      RESP_R2:                            w[1:0] = 2'd1;
      default:                            w[1:0] = 2'd0;
    endcase
    return w;
  endfunction

  // updates the tracking state and returns the result the block owes
  function automatic res_item_t predict_result(in_item_t it);
    res_item_t r;
    logic [25:0] nbytes;
    r      = '0;
    nbytes = it.transfer_bytes;
    if (it.cmd == ITEM_ISSUE) begin
      cmd_track = '0;
      if (!it.has_data) begin
        r.command_word          = command_word_for(it.cmd_index, it.response_kind, 1'b0);
        r.argument_out          = it.argument;
        cmd_track.waiting       = 1'b1;
        cmd_track.busy_response = (it.response_kind == RESP_R1B);
      end else if ((nbytes[8:0] != '0 && nbytes != SHORT_BYTES) ||
                   nbytes > MAX_DATA_BYTES) begin
        r.done_res = 1'b1;
        r.outcome  = OUT_NOT_SUPP;
      end else begin
        if (nbytes > ONE_BLOCK) begin
          r.transfer_mode_word[TM_MULTI]   = 1'b1;
          r.transfer_mode_word[TM_BCNT_EN] = 1'b1;
          r.block_count                    = nbytes[24:9];
        end
        r.transfer_mode_word[TM_READ]   = it.read_dir;
        r.transfer_mode_word[TM_ACMD12] = (nbytes != SHORT_BYTES);
        r.command_word = command_word_for(it.cmd_index, it.response_kind, 1'b1);
        r.argument_out = it.argument;
        r.done_res     = 1'b1;
      end
    end else if (cmd_track.waiting && it.normal_status != '0) begin
      r.ack_normal = it.normal_status;
      if (it.normal_status[NS_ERROR]) begin
        r.ack_error = it.error_status;
        r.done_res  = 1'b1;
        // error bits by priority
        if (it.error_status[8])
          r.outcome = it.acmd_err_status[1] ? OUT_CMD_TIMEOUT : OUT_CMD_ERROR;
        else if (it.error_status[6:5] != '0) r.outcome = OUT_DATA_ERROR;
        else if (it.error_status[4])         r.outcome = OUT_DATA_TIMEOUT;
        else if (it.error_status[3:1] != '0) r.outcome = OUT_CMD_ERROR;
        else if (it.error_status[0])         r.outcome = OUT_CMD_TIMEOUT;
        else                                 r.outcome = OUT_CMD_ERROR;
      end else if (it.normal_status[NS_REMOVAL]) begin
        r.done_res = 1'b1;
        r.outcome  = OUT_NO_CARD;
      end else if (!cmd_track.busy_response) begin
        r.done_res = 1'b1;
        r.outcome  = it.normal_status[NS_CMD_DONE] ? OUT_OK : OUT_WRONG_INT;
      end else begin
        if (it.normal_status[NS_CMD_DONE])  cmd_track.cmd_done_seen  = 1'b1;
        if (it.normal_status[NS_XFER_DONE]) cmd_track.xfer_done_seen = 1'b1;
        r.done_res = cmd_track.cmd_done_seen && cmd_track.xfer_done_seen;
      end
      if (r.done_res) cmd_track = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    res_item_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", 32'(out_item_i.command_word),
                          '0);
        end else begin
          want = expected_results.pop_front();
          if (out_item_i.done_res != want.done_res)
            report_mismatch("done_res", 32'(out_item_i.done_res), 32'(want.done_res));
          if (out_item_i.outcome != want.outcome)
            report_mismatch("outcome", 32'(out_item_i.outcome), 32'(want.outcome));
          if (out_item_i.command_word != want.command_word)
            report_mismatch("command_word", 32'(out_item_i.command_word),
                            32'(want.command_word));
          if (out_item_i.transfer_mode_word != want.transfer_mode_word)
            report_mismatch("transfer_mode_word", 32'(out_item_i.transfer_mode_word),
                            32'(want.transfer_mode_word));
          if (out_item_i.block_count != want.block_count)
            report_mismatch("block_count", 32'(out_item_i.block_count),
                            32'(want.block_count));
          if (out_item_i.argument_out != want.argument_out)
            report_mismatch("argument_out", out_item_i.argument_out, want.argument_out);
          if (out_item_i.ack_normal != want.ack_normal)
            report_mismatch("ack_normal", 32'(out_item_i.ack_normal),
                            32'(want.ack_normal));
          if (out_item_i.ack_error != want.ack_error)
            report_mismatch("ack_error", 32'(out_item_i.ack_error), 32'(want.ack_error));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(predict_result(in_item_i));
      pending_o    <= expected_results.size();
      mismatches_o <= mismatch_count;
    end
  end

endmodule

[tb/sd_host_command_tracker_tb.sv]
// ----------------------------------------------------------------------------
// sd_host_command_tracker_tb
// drives command-issue and interrupt-status items into the tracker with
// random gaps and back-pressure; a checker beside the block predicts and
// compares every result, this module only makes stimulus and the verdict
// ----------------------------------------------------------------------------
module sd_host_command_tracker_tb;
  import sdht_pkg::*;

  // response kind outside the defined set, tracked with no response type
  localparam logic [2:0] RESP_UNKNOWN = 3'd7;

  localparam int ITEMS_WANTED   = 1750;
  localparam int WATCHDOG_LIMIT = 5000;   // far beyond the longest hold-off
  localparam int HOLD_OFF       = 300;    // long receiver stall to fill the block
  localparam int DRAIN_CYCLES   = 8;      // settling margin after the drain

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  res_item_t out_item;

  int        mismatches;
  int        pending;
  int        items_sent;
  logic      calm;         // no random gaps on either side while set

  sd_host_command_tracker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  sd_host_command_tracker_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // wait before the next item, none during calm stretches
  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // every field random, so unused fields toggle too
  function automatic in_item_t noise_item();
    in_item_t it;
    it.cmd             = 1'($urandom);
    it.cmd_index       = 6'($urandom);
    it.argument        = $urandom;
    it.response_kind   = 3'($urandom);
    it.has_data        = 1'($urandom);
    it.read_dir        = 1'($urandom);
    it.transfer_bytes  = 26'($urandom);
    it.normal_status   = 16'($urandom);
    it.error_status    = 16'($urandom);
    it.acmd_err_status = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t issue_item(logic [2:0] kind, logic data, logic [25:0] nbytes);
    in_item_t it;
    it                = noise_item();
    it.cmd            = ITEM_ISSUE;
    it.response_kind  = kind;
    it.has_data       = data;
    it.transfer_bytes = nbytes;
    return it;
  endfunction

  function automatic in_item_t status_item(logic [15:0] nst, logic [15:0] est,
                                           logic [15:0] acmd);
    in_item_t it;
    it                 = noise_item();
    it.cmd             = ITEM_STATUS;
    it.normal_status   = nst;
    it.error_status    = est;
    it.acmd_err_status = acmd;
    return it;
  endfunction

  // error words: fully random, one bit alone, or empty
  function automatic logic [15:0] error_word();
    case ($urandom_range(0, 2))
      0:       return 16'($urandom);
      1:       return 16'(1 << $urandom_range(0, 15));
      default: return '0;
    endcase
  endfunction

  // offer one item after a random gap and hold it until taken
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
  endtask

  // plain command: one status item normally ends it, or it is abandoned
  task automatic plain_command();
    logic [2:0]  kind;
    logic [15:0] nst;
    kind = 3'($urandom);
    if (kind == RESP_R1B) kind = RESP_R1;
    send_item(issue_item(kind, 1'b0, 26'($urandom)));
    if ($urandom_range(0, 3) == 0) send_item(status_item('0, error_word(), 16'($urandom)));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: nst = (16'($urandom) & ~16'h8080) | 16'h0001;
      4: begin
        nst = 16'($urandom) & ~16'h8081;
        if (nst == '0) nst = 16'h0002;
      end
      5, 6: nst = 16'($urandom) | 16'h8000;
      7:    nst = (16'($urandom) & ~16'h8000) | 16'h0080;
      8:    return;   // left in flight, the next issue abandons it
      default: nst = 16'($urandom);
    endcase
    send_item(status_item(nst, error_word(), 16'($urandom)));
  endtask

  // busy command: needs command and transfer complete, often split
  task automatic busy_command();
    logic        cmd_seen;
    logic        xfer_seen;
    logic [15:0] nst;
    cmd_seen  = 1'b0;
    xfer_seen = 1'b0;
    send_item(issue_item(RESP_R1B, 1'b0, 26'($urandom)));
    while (!(cmd_seen && xfer_seen)) begin
      case ($urandom_range(0, 11))
        0:  nst = 16'($urandom) | 16'h8000;
        1:  nst = (16'($urandom) & ~16'h8000) | 16'h0080;
        2:  nst = '0;
        default: nst = (16'($urandom) & ~16'h8083) | 16'($urandom_range(0, 3));
      endcase
      send_item(status_item(nst, error_word(), 16'($urandom)));
      if (nst[15] || nst[7]) return;
      cmd_seen  |= nst[0];
      xfer_seen |= nst[1];
    end
  endtask

  task automatic data_command();
    logic [25:0] nbytes;
    case ($urandom_range(0, 5))
      0:       nbytes = '0;
      1:       nbytes = SHORT_BYTES;
      2:       nbytes = ONE_BLOCK;
      3:       nbytes = 26'($urandom_range(2, 16) * BLOCK_BYTES);
      4:       nbytes = 26'($urandom_range(1, MAX_BLOCKS) * BLOCK_BYTES);
      default: nbytes = MAX_DATA_BYTES;
    endcase
    send_item(issue_item(3'($urandom), 1'b1, nbytes));
  endtask

  task automatic bad_size_command();
    logic [25:0] nbytes;
    case ($urandom_range(0, 3))
      0: nbytes = 26'($urandom);
      1: nbytes = 26'($urandom_range(1, 16) * BLOCK_BYTES + $urandom_range(1, 511));
      2: nbytes = MAX_DATA_BYTES + 26'($urandom_range(1, 16) * BLOCK_BYTES);
      default: nbytes = ($urandom_range(0, 1) != 0) ? 26'($urandom_range(0, 7))
                                                    : 26'($urandom_range(9, 511));
    endcase
    send_item(issue_item(3'($urandom), 1'b1, nbytes));
  endtask

  // result side: random stalls per item, two long hold-offs so the block
  // fills and pushes back on the sender
  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    out_stall = 1'b0;
    taken     = 0;
    @(posedge rst_n);
    forever begin
      hold = (taken == 400 || taken == 1300) ? HOLD_OFF : draw_gap();
      if (hold != 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  // ends the run if nothing moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("sd_host_command_tracker_tb failed");
    $finish;
  end

  initial begin : stimulus
    in_item_t it;
    in_valid   = 1'b0;
    in_item    = '0;
    rst_n      = 1'b0;
    calm       = 1'b0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: status while idle, field extremes, every response kind,
    // every outcome but command error and the data size corners
    send_item(status_item(16'hFFFF, 16'hFFFF, 16'hFFFF));
    it = issue_item(RESP_NONE, 1'b0, '0);
    it.cmd_index = 6'h3F;
    it.argument  = 32'hFFFF_FFFF;
    send_item(it);
    send_item(status_item('0, 16'hFFFF, '0));                 // zero normal status
    send_item(status_item(16'h0001, '0, '0));                  // ok
    it = issue_item(RESP_R1, 1'b0, '0);
    it.cmd_index = '0;
    it.argument  = '0;
    send_item(it);
    send_item(status_item(16'h0002, '0, '0));                  // wrong interrupt
    send_item(issue_item(RESP_R1B, 1'b0, '0));
    send_item(status_item(16'h0001, '0, '0));                  // busy, half done
    send_item(status_item(16'h0002, '0, '0));                  // busy, finished
    send_item(issue_item(RESP_R2, 1'b0, '0));
    send_item(status_item(16'h8000, 16'h0100, 16'h0002));      // auto cmd timeout
    send_item(issue_item(RESP_R3, 1'b0, '0));
    send_item(status_item(16'h8001, 16'h0040, '0));            // data error
    send_item(issue_item(RESP_R6, 1'b0, '0));
    send_item(status_item(16'h8000, 16'h0010, '0));            // data timeout
    send_item(issue_item(RESP_R7, 1'b0, '0));
    send_item(issue_item(RESP_UNKNOWN, 1'b0, '0));             // abandons the one before
    send_item(status_item(16'h8000, 16'h0001, '0));            // cmd timeout
    send_item(issue_item(RESP_R1, 1'b0, '0));
    send_item(status_item(16'h0080, 16'hFFFF, '0));            // card removed
    send_item(issue_item(RESP_R1, 1'b1, '0));                  // empty transfer
    send_item(issue_item(RESP_R1, 1'b1, SHORT_BYTES));
    send_item(issue_item(RESP_R1, 1'b1, MAX_DATA_BYTES));
    send_item(issue_item(RESP_R1, 1'b1, ONE_BLOCK + 26'd1));  // rejected size
    send_item(issue_item(RESP_R1, 1'b1, 26'h3FF_FFFF));        // rejected size

    // random: mostly well-formed command sequences, some noise
    while (items_sent < ITEMS_WANTED) begin
      calm = (items_sent % 300) < 60;
      case ($urandom_range(0, 99)) inside
        [0:29]:  plain_command();
        [30:49]: busy_command();
        [50:69]: data_command();
        [70:84]: bad_size_command();
        default: send_item(noise_item());
      endcase
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain; the watchdog bounds this wait
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("sd_host_command_tracker_tb passed");
    end else begin
      $display("sd_host_command_tracker_tb failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/sdht_pkg.sv
hdl/sdht_issue.sv
hdl/sdht_tracker.sv
hdl/sd_host_command_tracker.sv
tb/sd_host_command_tracker_checker.sv
tb/sd_host_command_tracker_tb.sv
